### sv/pat_pkg.sv
// positional array table: shared types and codes
// request and response payload structs, operation kinds, status codes
// no dependencies
package pat_pkg;

   localparam int unsigned DATA_W = 32;

   // operation kinds
   localparam logic [2:0] KIND_CLEAR  = 3'd0;
   localparam logic [2:0] KIND_READ   = 3'd1;
   localparam logic [2:0] KIND_INSERT = 3'd2;
   localparam logic [2:0] KIND_DELETE = 3'd3;
   localparam logic [2:0] KIND_SEARCH = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_FULL   = 3'd1;
   localparam logic [2:0] ST_EMPTY  = 3'd2;
   localparam logic [2:0] ST_BADPOS = 3'd3;
   localparam logic [2:0] ST_NOTFND = 3'd4;

   typedef struct packed {
      logic [2:0]               kind;
      logic [7:0]               position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]               status;
      logic signed [DATA_W-1:0] read_value;
      logic [7:0]               found_position;
      logic [7:0]               entry_count;
   } rsp_type;

endpackage

### sv/pat_ram.sv
// positional array table: entry storage
// one write port, one read port with registered read data
// depends on pat_pkg
module pat_ram #(
   parameter int unsigned DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic signed [pat_pkg::DATA_W-1:0]   wr_data,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic signed [pat_pkg::DATA_W-1:0]   rd_data
);
   import pat_pkg::*;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/positional_array_table.sv
// positional array table: top level with operation sequencer
// holds entry count, walks the entry ram one entry per cycle
// depends on pat_pkg and pat_ram
//
// usage
//  - req channel (req_valid/req_ready/req_data) takes one operation per request:
//    clear, read, insert, delete or search; req_ready is high only while the
//    sequencer is idle, so one request is in work at a time
//  - rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one response
//    per request, in order, from an output register
//  - insert and delete run longer the more entries they move, search until
//    a match or the last entry; clear, read, deleting the last entry,
//    unknown kinds and errors need no walk
//  - the single read and single write port of the entry ram sets the pace:
//    one entry move or one compare per cycle, reads overlapped with writes
//  - the next request is taken once the previous response sits in the
//    output register, even while the receiver still stalls it
//  - a stalled response holds; a finished operation then waits in the
//    sequencer until the output register frees up
//  - reset empties the table (count to zero) and drops any response;
//    the ram is not cleared, entries past the count are never read
module positional_array_table #(
   parameter int unsigned DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pat_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pat_pkg::rsp_type  rsp_data
);
   import pat_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   // compare width: holds both position and count plus one spare bit
   localparam int unsigned PW = ((CW > 8) ? CW : 8) + 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_UP,
      S_DOWN,
      S_DRAIN,
      S_PUT,
      S_SRCH,
      S_SLAST,
      S_DONE
   } state_type;

   // control state
   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           pend_ff, pend_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [2:0]               kind_ff, kind_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [AW-1:0]            src_ff, src_in;
   logic [AW-1:0]            dst_ff, dst_in;
   logic [AW-1:0]            stop_ff, stop_in;
   logic [2:0]               status_ff, status_in;
   logic signed [DATA_W-1:0] rdv_ff, rdv_in;
   logic [7:0]               fpos_ff, fpos_in;
   rsp_type                  rsp_ff, rsp_in;

   // ram port
   logic                     ram_we;
   logic [AW-1:0]            ram_waddr;
   logic signed [DATA_W-1:0] ram_wdata;
   logic [AW-1:0]            ram_raddr;
   logic signed [DATA_W-1:0] ram_rdata;

   // position and count views
   logic [PW-1:0] pos_w, cnt_w, cnt_p1;
   logic [CW-1:0] cnt_m1;
   logic [AW-1:0] pos_a;
   logic [31:0]   fpos_wide, cnt_wide;
   logic          req_fire;
   logic          rsp_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign pos_w     = PW'(req_data.position);
   assign cnt_w     = PW'(count_ff);
   assign cnt_p1    = cnt_w + PW'(1);
   assign cnt_m1    = count_ff - CW'(1);
   assign pos_a     = AW'(req_data.position);
   assign fpos_wide = 32'(dst_ff) + 32'd1;
   assign cnt_wide  = 32'(count_ff);

   pat_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      val_in       = val_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      stop_in      = stop_ff;
      status_in    = status_ff;
      rdv_in       = rdv_ff;
      fpos_in      = fpos_ff;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = dst_ff;
      ram_wdata    = ram_rdata;
      ram_raddr    = src_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in   = req_data.kind;
               val_in    = req_data.value;
               pend_in   = 1'b0;
               status_in = ST_OK;
               rdv_in    = '0;
               fpos_in   = '0;
               state_in  = S_DONE;
               unique case (req_data.kind)
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  KIND_READ: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (pos_w == '0 || pos_w > cnt_w) begin
                        status_in = ST_BADPOS;
                     end else begin
                        ram_raddr = pos_a - AW'(1);
                        state_in  = S_READ;
                     end
                  end
                  KIND_INSERT: begin
                     // full is checked before the position
                     if (cnt_w == PW'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else if (pos_w == '0 || pos_w > cnt_p1) begin
                        status_in = ST_BADPOS;
                     end else begin
                        stop_in = pos_a - AW'(1);
                        src_in  = AW'(cnt_m1);
                        // append needs no shift
                        if (pos_w == cnt_p1) begin
                           state_in = S_PUT;
                        end else begin
                           state_in = S_UP;
                        end
                     end
                  end
                  KIND_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (pos_w == '0 || pos_w > cnt_w) begin
                        status_in = ST_BADPOS;
                     end else if (pos_w == cnt_w) begin
                        // last entry: just drop it
                        count_in = cnt_m1;
                     end else begin
                        src_in   = pos_a;
                        stop_in  = AW'(cnt_m1);
                        state_in = S_DOWN;
                     end
                  end
                  KIND_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        src_in   = '0;
                        stop_in  = AW'(cnt_m1);
                        state_in = S_SRCH;
                     end
                  end
                  default: begin
                     // unknown kind: no change, status ok
                  end
               endcase
            end
         end

         S_READ: begin
            rdv_in   = ram_rdata;
            state_in = S_DONE;
         end

         // insert shift: read entry src, write it one slot up next cycle
         S_UP: begin
            ram_raddr = src_ff;
            ram_we    = pend_ff;
            pend_in   = 1'b1;
            dst_in    = src_ff + AW'(1);
            if (src_ff == stop_ff) begin
               state_in = S_DRAIN;
            end else begin
               src_in = src_ff - AW'(1);
            end
         end

         // delete shift: read entry src, write it one slot down next cycle
         S_DOWN: begin
            ram_raddr = src_ff;
            ram_we    = pend_ff;
            pend_in   = 1'b1;
            dst_in    = src_ff - AW'(1);
            if (src_ff == stop_ff) begin
               state_in = S_DRAIN;
            end else begin
               src_in = src_ff + AW'(1);
            end
         end

         S_DRAIN: begin
            ram_we  = 1'b1;
            pend_in = 1'b0;
            if (kind_ff == KIND_INSERT) begin
               state_in = S_PUT;
            end else begin
               count_in = cnt_m1;
               state_in = S_DONE;
            end
         end

         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = stop_ff;
            ram_wdata = val_ff;
            count_in  = count_ff + CW'(1);
            state_in  = S_DONE;
         end

         // search: compare last cycle's read while issuing the next one
         S_SRCH: begin
            if (pend_ff && ram_rdata == val_ff) begin
               status_in = ST_OK;
               fpos_in   = fpos_wide[7:0];
               pend_in   = 1'b0;
               state_in  = S_DONE;
            end else begin
               ram_raddr = src_ff;
               pend_in   = 1'b1;
               dst_in    = src_ff;
               if (src_ff == stop_ff) begin
                  state_in = S_SLAST;
               end else begin
                  src_in = src_ff + AW'(1);
               end
            end
         end

         S_SLAST: begin
            pend_in = 1'b0;
            if (ram_rdata == val_ff) begin
               status_in = ST_OK;
               fpos_in   = fpos_wide[7:0];
            end else begin
               status_in = ST_NOTFND;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (rsp_free) begin
               rsp_in.status         = status_ff;
               rsp_in.read_value     = rdv_ff;
               rsp_in.found_position = fpos_ff;
               rsp_in.entry_count    = cnt_wide[7:0];
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff   <= kind_in;
      val_ff    <= val_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      stop_ff   <= stop_in;
      status_ff <= status_in;
      rdv_ff    <= rdv_in;
      fpos_ff   <= fpos_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // count never runs past the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("entry count above depth");

   // an accepted request keeps the sequencer busy the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sequencer idle right after accept");

   // the ram is only written while an insert or delete is in work
   a_write_owner: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (kind_ff == KIND_INSERT || kind_ff == KIND_DELETE))
      else $error("ram write outside insert or delete");

   // responses carry a defined status code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= ST_NOTFND))
      else $error("undefined status code");
`endif

endmodule
